>>> rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/cdq_ram.sv
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cdq_ctrl.sv
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/cdq_dp.sv
module cdq_dp
  import cdq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [DATA_W-1:0]   push_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DATA_W-1:0]   pop_value_o,
  output logic [STAT_W-1:0]   status_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  op_e                op_q;
  logic [DATA_W-1:0]  val_q;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [IDX_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  status_e            res_q, res_d;
  logic               pop_ok_q, pop_ok_d;
  logic [DATA_W-1:0]  out_data_q;
  status_e            out_stat_q;
  logic               out_valid_q;

  logic               full, empty;
  logic [IDX_W-1:0]   head_next, head_prev, tail_next, tail_prev;
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  assign full      = (count_q == FULL_CNT);
  assign empty     = (count_q == '0);
  assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
  assign tail_next = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
  assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    res_d     = res_q;
    pop_ok_d  = pop_ok_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = tail_q;
    ram_raddr = head_q;
    if (cmd_i.exec) begin
      res_d    = ST_OK;
      pop_ok_d = 1'b0;
      case (op_q)
        OP_PUSH_BACK: begin
          if (full) begin
            res_d = ST_FULL;
          end else begin
            ram_we  = 1'b1;
            tail_d  = tail_next;
            count_d = count_q + 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          ram_waddr = head_prev;
          if (full) begin
            res_d = ST_FULL;
          end else begin
            ram_we  = 1'b1;
            head_d  = head_prev;
            count_d = count_q + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res_d = ST_EMPTY;
          end else begin
            ram_re   = 1'b1;
            pop_ok_d = 1'b1;
            head_d   = head_next;
            count_d  = count_q - 1'b1;
          end
        end
        OP_POP_BACK: begin
          ram_raddr = tail_prev;
          if (empty) begin
            res_d = ST_EMPTY;
          end else begin
            ram_re   = 1'b1;
            pop_ok_d = 1'b1;
            tail_d   = tail_prev;
            count_d  = count_q - 1'b1;
          end
        end
        default: begin
          res_d = ST_OK;
        end
      endcase
    end
  end

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= op_e'(op_i);
      val_q <= push_value_i;
    end
    res_q    <= res_d;
    pop_ok_q <= pop_ok_d;
    if (cmd_i.load_out) begin
      out_data_q <= pop_ok_q ? ram_rdata : '0;
      out_stat_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign pop_value_o     = out_data_q;
  assign status_o        = out_stat_q;

endmodule

>>> rtl/circular_deque.sv
// An item passes the input register, the registered read of the entry RAM and
// the output register. The controller steps through accept, execute and load
// and takes no new item until load is done; load waits on an untaken result.
// A result waiting in the output register does not stop the next item's accept.
// Reset (rst_ni low, asynchronous): head, tail, count and output valid clear;
// the entry RAM is not cleared.
module circular_deque
  import cdq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,  // [31:0] push_value
  input  logic [OP_W-1:0]   s_axis_tuser,  // [1:0] operation
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,  // [31:0] pop_value
  output logic [STAT_W-1:0] m_axis_tuser   // [1:0] status
);

  cmd_t  cmd;
  stat_t stat;

  cdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cdq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (s_axis_tuser),
    .push_value_i (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pop_value_o  (m_axis_tdata),
    .status_o     (m_axis_tuser)
  );

endmodule

>>> rtl/cdq_checker.sv
module cdq_checker
  import cdq_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic [STAT_W-1:0] m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_FULL) || (m_axis_tuser == ST_EMPTY))
    else $error("undefined status code");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("refused operation returned data");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("item accepted while another is in flight");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
